// File: src/tsa_pkg.sv
// shared constants and types for the typed slot allocator
package tsa_pkg;

    localparam int BANKS          = 4;
    localparam int SLOTS_PER_BANK = 16;
    localparam int ID_WIDTH       = 32;
    localparam int TOTAL_SLOTS    = BANKS * SLOTS_PER_BANK;
    localparam int BANK_W         = $clog2(BANKS);
    localparam int SLOT_W         = $clog2(SLOTS_PER_BANK);
    localparam int FLAT_W         = BANK_W + SLOT_W;
    localparam int CNT_W          = SLOT_W + 1;
    localparam int NB_W           = BANK_W + 1;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_COUNT  = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_LAST  = 2'd1;
    localparam logic [1:0] POL_LEAST = 2'd2;
    localparam logic [1:0] POL_RR    = 2'd3;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_BANKS  = 2'd1;
    localparam logic [1:0] REG_TYPES  = 2'd2;
    localparam logic [1:0] REG_SIZES  = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic                load;      // capture request, clear scan
        logic                scan_step; // examine one slot at scan_idx
        logic [FLAT_W-1:0]   scan_idx;
        logic                write;     // commit allocation
        logic                release_slot;
        logic                finish;    // drive result strobe
    } ctl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0]        mode;
        logic              id_found;
        logic              alloc_ok;
    } dp_stat_t;

endpackage

// File: src/tsa_datapath.sv
// slot memory, scan evaluation and result registers of the typed slot allocator
module tsa_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [1:0]                 cfg_index,
    input  logic [19:0]                cfg_data,
    input  logic [1:0]                 mode,
    input  logic [31:0]                vehicle_id,
    input  logic [1:0]                 vehicle_type,
    input  logic [1:0]                 bank_index,
    input  tsa_pkg::ctl_cmd_t          cmd,
    output tsa_pkg::dp_stat_t          stat,
    output logic                       done,
    output logic                       ok,
    output logic [1:0]                 bank,
    output logic [3:0]                 slot,
    output logic [4:0]                 free_count
);
    import tsa_pkg::*;

    logic [1:0]            policy_reg;
    logic [2:0]            banks_reg;
    logic [7:0]            types_reg;
    logic [19:0]           sizes_reg;
    logic [TOTAL_SLOTS-1:0] occ_reg;
    logic [ID_WIDTH-1:0]   holder_mem [TOTAL_SLOTS];
    logic [ID_WIDTH-1:0]   holder_rd_reg;
    logic [BANK_W-1:0]     next_bank_reg;

    logic [1:0]            mode_reg;
    logic [ID_WIDTH-1:0]   id_reg;
    logic [1:0]            type_reg;
    logic [1:0]            bidx_reg;

    logic                  found_reg;
    logic [FLAT_W-1:0]     found_pos_reg;
    logic                  first_reg;   // first fit in whole pass
    logic [FLAT_W-1:0]     first_pos_reg;
    logic                  last_reg;
    logic [FLAT_W-1:0]     last_pos_reg;
    logic                  bfirst_reg;  // first fit in current bank
    logic [SLOT_W-1:0]     bfirst_slot_reg;
    logic [CNT_W-1:0]      bcnt_reg;
    logic [CNT_W-1:0]      best_cnt_reg;
    logic                  best_ok_reg;
    logic [FLAT_W-1:0]     best_pos_reg;
    logic [CNT_W-1:0]      req_cnt_reg;
    logic [NB_W-1:0]       rr_dist_reg;
    logic                  rr_ok_reg;
    logic [FLAT_W-1:0]     rr_pos_reg;

    logic                  done_reg;
    logic                  ok_reg;
    logic [1:0]            bank_reg;
    logic [3:0]            slot_reg;
    logic [4:0]            cnt_out_reg;

    logic [NB_W-1:0]       n_act;
    logic [BANK_W-1:0]     sb;
    logic [SLOT_W-1:0]     ss;
    logic [4:0]            size_raw;
    logic [CNT_W-1:0]      size_b;
    logic [1:0]            type_b;
    logic                  in_use_b;
    logic                  fits;
    logic                  hit;
    logic [FLAT_W-1:0]     rd_addr;
    logic [BANK_W-1:0]     rr_start;
    logic [NB_W-1:0]       rr_dist;
    logic [CNT_W-1:0]      bcnt_new;
    logic                  bfirst_new;
    logic [SLOT_W-1:0]     bfirst_slot_new;
    logic                  slot_end;
    logic                  sel_ok;
    logic [FLAT_W-1:0]     sel_pos;
    logic [NB_W:0]         nb_sum;

    assign n_act    = (banks_reg > 3'(BANKS)) ? NB_W'(BANKS) : NB_W'(banks_reg);
    assign sb       = cmd.scan_idx[FLAT_W-1:SLOT_W];
    assign ss       = cmd.scan_idx[SLOT_W-1:0];
    assign size_raw = sizes_reg[5*sb +: 5];
    assign size_b   = (size_raw > 5'(SLOTS_PER_BANK)) ? CNT_W'(SLOTS_PER_BANK)
                                                       : CNT_W'(size_raw);
    assign type_b   = types_reg[2*sb +: 2];
    assign in_use_b = NB_W'(sb) < n_act;
    assign fits     = (CNT_W'(ss) < size_b) && (type_b == type_reg) && !occ_reg[cmd.scan_idx];
    assign hit      = occ_reg[cmd.scan_idx] && (holder_rd_reg == id_reg);
    assign slot_end = (ss == SLOT_W'(SLOTS_PER_BANK - 1));

    // holder read runs one slot ahead of the scan
    assign rd_addr  = cmd.scan_step ? (cmd.scan_idx + FLAT_W'(1)) : cmd.scan_idx;

    // round robin start is next_bank mod active banks
    always_comb
    begin
        case (n_act)
            NB_W'(1): rr_start = '0;
            NB_W'(2): rr_start = {1'b0, next_bank_reg[0]};
            NB_W'(3): rr_start = (next_bank_reg == BANK_W'(3)) ? '0 : next_bank_reg;
            default:  rr_start = next_bank_reg;
        endcase
    end

    assign rr_dist  = (sb >= rr_start) ? NB_W'(sb - rr_start)
                                       : NB_W'(NB_W'(sb) + n_act - NB_W'(rr_start));

    assign bcnt_new        = bcnt_reg + CNT_W'(fits);
    assign bfirst_new      = bfirst_reg || fits;
    assign bfirst_slot_new = bfirst_reg ? bfirst_slot_reg : ss;

    always_comb
    begin
        case (policy_reg)
            POL_FIRST:
            begin
                sel_ok  = first_reg;
                sel_pos = first_pos_reg;
            end
            POL_LAST:
            begin
                sel_ok  = last_reg;
                sel_pos = last_pos_reg;
            end
            POL_LEAST:
            begin
                sel_ok  = best_ok_reg;
                sel_pos = best_pos_reg;
            end
            default:
            begin
                sel_ok  = rr_ok_reg;
                sel_pos = rr_pos_reg;
            end
        endcase
        if (n_act == '0)
        begin
            sel_ok = 1'b0;
        end
    end

    assign nb_sum = (NB_W+1)'(sel_pos[FLAT_W-1:SLOT_W]) + (NB_W+1)'(1);

    assign stat.mode     = mode_reg;
    assign stat.id_found = found_reg;
    assign stat.alloc_ok = sel_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= '0;
            banks_reg     <= 3'd4;
            types_reg     <= '0;
            sizes_reg     <= '0;
            occ_reg       <= '0;
            next_bank_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_POLICY: policy_reg <= cfg_data[1:0];
                    REG_BANKS:  banks_reg  <= cfg_data[2:0];
                    REG_TYPES:  types_reg  <= cfg_data[7:0];
                    REG_SIZES:  sizes_reg  <= cfg_data;
                    default:    policy_reg <= policy_reg;
                endcase
            end
            if (cmd.write)
            begin
                occ_reg[sel_pos] <= 1'b1;
                if (policy_reg == POL_RR)
                begin
                    next_bank_reg <= (nb_sum >= (NB_W+1)'(n_act)) ? '0
                                                                  : BANK_W'(nb_sum);
                end
            end
            if (cmd.release_slot)
            begin
                occ_reg[found_pos_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            holder_mem[sel_pos] <= id_reg;
        end
        holder_rd_reg <= holder_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= mode;
            id_reg       <= vehicle_id[ID_WIDTH-1:0];
            type_reg     <= vehicle_type;
            bidx_reg     <= bank_index;
            found_reg    <= 1'b0;
            first_reg    <= 1'b0;
            last_reg     <= 1'b0;
            bfirst_reg   <= 1'b0;
            bcnt_reg     <= '0;
            best_cnt_reg <= '0;
            best_ok_reg  <= 1'b0;
            req_cnt_reg  <= '0;
            rr_ok_reg    <= 1'b0;
            rr_dist_reg  <= '1;
        end
        else if (cmd.scan_step)
        begin
            if (hit && !found_reg)
            begin
                found_reg     <= 1'b1;
                found_pos_reg <= cmd.scan_idx;
            end
            if (in_use_b && fits)
            begin
                if (!first_reg)
                begin
                    first_reg     <= 1'b1;
                    first_pos_reg <= cmd.scan_idx;
                end
                last_reg     <= 1'b1;
                last_pos_reg <= cmd.scan_idx;
            end
            if (slot_end)
            begin
                bcnt_reg   <= '0;
                bfirst_reg <= 1'b0;
                if (sb == bidx_reg[BANK_W-1:0])
                begin
                    req_cnt_reg <= bcnt_new;
                end
                if (in_use_b)
                begin
                    if (sb == '0 || bcnt_new > best_cnt_reg)
                    begin
                        best_cnt_reg <= bcnt_new;
                        best_ok_reg  <= bfirst_new;
                        best_pos_reg <= {sb, bfirst_slot_new};
                    end
                    if (bfirst_new && rr_dist < rr_dist_reg)
                    begin
                        rr_dist_reg <= rr_dist;
                        rr_ok_reg   <= 1'b1;
                        rr_pos_reg  <= {sb, bfirst_slot_new};
                    end
                end
            end
            else
            begin
                bcnt_reg        <= bcnt_new;
                bfirst_reg      <= bfirst_new;
                bfirst_slot_reg <= bfirst_slot_new;
            end
        end
        if (cmd.finish)
        begin
            ok_reg      <= 1'b0;
            bank_reg    <= '0;
            slot_reg    <= '0;
            cnt_out_reg <= '0;
            case (mode_reg)
                MODE_ALLOC:
                begin
                    if (!found_reg && sel_ok)
                    begin
                        ok_reg   <= 1'b1;
                        bank_reg <= 2'(sel_pos[FLAT_W-1:SLOT_W]);
                        slot_reg <= 4'(sel_pos[SLOT_W-1:0]);
                    end
                end
                MODE_COUNT:
                begin
                    if (NB_W'(bidx_reg) < n_act)
                    begin
                        ok_reg      <= 1'b1;
                        bank_reg    <= bidx_reg;
                        cnt_out_reg <= 5'(req_cnt_reg);
                    end
                end
                default:
                begin
                    if (found_reg)
                    begin
                        ok_reg   <= 1'b1;
                        bank_reg <= 2'(found_pos_reg[FLAT_W-1:SLOT_W]);
                        slot_reg <= 4'(found_pos_reg[SLOT_W-1:0]);
                    end
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign ok         = ok_reg;
    assign bank       = bank_reg;
    assign slot       = slot_reg;
    assign free_count = cnt_out_reg;

endmodule

// File: src/tsa_ctrl.sv
// request sequencer of the typed slot allocator
module tsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tsa_pkg::dp_stat_t    stat,
    output tsa_pkg::ctl_cmd_t    cmd
);
    import tsa_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_OUT} state_t;

    state_t              state_reg;
    logic [FLAT_W-1:0]   idx_reg;
    logic                last;

    assign last = (idx_reg == FLAT_W'(TOTAL_SLOTS - 1));
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd              = '0;
        cmd.scan_idx     = idx_reg;
        case (state_reg)
            S_IDLE:   cmd.load = start;
            S_SCAN:   cmd.scan_step = 1'b1;
            S_DECIDE:
            begin
                cmd.finish       = 1'b1;
                cmd.write        = (stat.mode == MODE_ALLOC) && !stat.id_found
                                   && stat.alloc_ok;
                cmd.release_slot = (stat.mode == MODE_FREE) && stat.id_found;
            end
            default:  cmd.load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (start)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + FLAT_W'(1);
                    if (last)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: state_reg <= S_OUT;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/typed_slot_allocator.sv
// top level of the typed slot allocator
// Each request runs from start to the done strobe as one pass over all 64 slots,
// one slot a cycle through the single id compare and fit check, then the decide state and
// the output state; busy stays high until done. The result is on ok, bank, slot and
// free_count for the one cycle that done is high and cannot be stalled by the receiver.
// Configuration writes are always ready and should be made while busy is low.
module typed_slot_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] vehicle_id,
    input  logic [1:0]  vehicle_type,
    input  logic [1:0]  bank_index,
    output logic        done,
    output logic        ok,
    output logic [1:0]  bank,
    output logic [3:0]  slot,
    output logic [4:0]  free_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import tsa_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    tsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    tsa_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .vehicle_id   (vehicle_id),
        .vehicle_type (vehicle_type),
        .bank_index   (bank_index),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .ok           (ok),
        .bank         (bank),
        .slot         (slot),
        .free_count   (free_count)
    );

endmodule
